[sv/dwwn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwwn_pkg
// Shared widths, calendar tables and helper functions for the weekday and
// week number block.
// ----------------------------------------------------------------------------
package dwwn_pkg;

    // Field widths
    localparam int YEAR_BITS_DEF = 14;
    localparam int MONTH_W       = 4;
    localparam int DAY_W         = 5;
    localparam int WD_W          = 3;
    localparam int WK_W          = 6;
    localparam int DOY_W         = 9;

    // Month range
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

    // Reciprocal for the divide by 7 of the week offset (9-bit dividend)
    localparam int WK_DIV_K = DOY_W + 3;
    localparam int WK_DIV_M = ((1 << WK_DIV_K) + 6) / 7;
    localparam int WK_M_W   = WK_DIV_K - 2;
    localparam int WK_P_W   = DOY_W + WK_M_W;
    localparam int WK_Q_W   = WK_P_W - WK_DIV_K;

    // Result of the calendar stage
    typedef struct packed {
        logic             ok;
        logic             leap;
        logic [2:0]       jan1;   // weekday of January 1, 0 = Monday
        logic [DOY_W-1:0] offs;   // days since January 1
    } cal_t;

    // Length of a month; 0 for a month number outside the year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the months before month m
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DOY_W-1:0] cum;
        case (m)
            4'd1:    cum = 9'd0;
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        if (leap && (m > MONTH_FEB))
        begin
            cum = cum + 9'd1;
        end
        return cum;
    endfunction

    // Residue mod 7 of a value up to 15
    function automatic logic [2:0] mod7_small(input logic [3:0] v);
        logic [3:0] r;
        if (v >= 4'd14)
        begin
            r = v - 4'd14;
        end
        else if (v >= 4'd7)
        begin
            r = v - 4'd7;
        end
        else
        begin
            r = v;
        end
        return r[2:0];
    endfunction

endpackage

[sv/dwwn_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwwn_in_if / dwwn_out_if
// Valid/ready channels for dates going in and calendar results coming out.
// ----------------------------------------------------------------------------
interface dwwn_in_if #(
    parameter int YEAR_BITS = dwwn_pkg::YEAR_BITS_DEF
);
    import dwwn_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [YEAR_BITS-1:0] year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;

    modport source (output valid, output year, output month, output day, input ready);
    modport sink   (input valid, input year, input month, input day, output ready);
endinterface

interface dwwn_out_if;
    import dwwn_pkg::*;

    logic             valid;
    logic             ready;
    logic [WD_W-1:0]  weekday;
    logic [WK_W-1:0]  week_number;
    logic [DOY_W-1:0] day_of_year;
    logic             leap_year;
    logic             valid_res;

    modport source (output valid, output weekday, output week_number, output day_of_year,
                    output leap_year, output valid_res, input ready);
    modport sink   (input valid, input weekday, input week_number, input day_of_year,
                    input leap_year, input valid_res, output ready);
endinterface

[sv/dwwn_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwwn_div
// First stage: elapsed years before the date's year and the count of whole
// centuries in them, via a reciprocal multiply by 1/25.
// ----------------------------------------------------------------------------
module dwwn_div #(
    parameter int YEAR_BITS = dwwn_pkg::YEAR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [YEAR_BITS-1:0]          year,
    input  logic [dwwn_pkg::MONTH_W-1:0]  month,
    input  logic [dwwn_pkg::DAY_W-1:0]    day,
    output logic [YEAR_BITS-1:0]          elapsed,
    output logic [YEAR_BITS-7:0]          centuries,
    output logic [dwwn_pkg::MONTH_W-1:0]  mon,
    output logic [dwwn_pkg::DAY_W-1:0]    mday,
    output logic                          date_ok
);
    import dwwn_pkg::*;

    localparam int Q4_W   = YEAR_BITS - 2;
    localparam int Q100_W = YEAR_BITS - 6;
    localparam int DIV_K  = Q4_W + 5;
    localparam int DIV_M  = ((1 << DIV_K) + 24) / 25;
    localparam int M_W    = DIV_K - 4;
    localparam int P_W    = Q4_W + M_W;

    logic [YEAR_BITS-1:0] elapsed_next;
    logic [Q4_W-1:0]      quads;
    logic [P_W-1:0]       prod;
    logic [Q100_W-1:0]    centuries_next;
    logic                 date_ok_next;

    // Years before this one; floor(r/100) = floor((r/4)/25)
    assign elapsed_next   = year - YEAR_BITS'(1);
    assign quads          = elapsed_next[YEAR_BITS-1:2];
    assign prod           = P_W'(quads) * P_W'(DIV_M);
    assign centuries_next = prod[DIV_K +: Q100_W];

    // Year and month range
    assign date_ok_next = (year != '0) && (month inside {[MONTH_FIRST:MONTH_LAST]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            elapsed   <= elapsed_next;
            centuries <= centuries_next;
            mon       <= month;
            mday      <= day;
            date_ok   <= date_ok_next;
        end
    end

endmodule

[sv/dwwn_cal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwwn_cal
// Second stage: leap flag, weekday of January 1, ordinal offset of the date
// and the day-of-month range check.
// ----------------------------------------------------------------------------
module dwwn_cal #(
    parameter int YEAR_BITS = dwwn_pkg::YEAR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [YEAR_BITS-1:0]          elapsed,
    input  logic [YEAR_BITS-7:0]          centuries,
    input  logic [dwwn_pkg::MONTH_W-1:0]  mon,
    input  logic [dwwn_pkg::DAY_W-1:0]    mday,
    input  logic                          date_ok,
    output dwwn_pkg::cal_t                cal
);
    import dwwn_pkg::*;

    localparam int Q4_W   = YEAR_BITS - 2;
    localparam int Q100_W = YEAR_BITS - 6;
    localparam int S_W    = YEAR_BITS + 1;
    localparam int ND     = (S_W + 2) / 3;
    localparam int EXT_W  = 3 * ND;

    logic [Q4_W-1:0]   quads;
    logic [Q100_W-3:0] quad_cent;
    logic [6:0]        cent_mul;
    logic [6:0]        rem100;
    logic [8:0]        quad_mul;
    logic [8:0]        rem400;
    logic              leap;
    logic [S_W-1:0]    day_sum;
    logic [EXT_W-1:0]  sum_ext;
    logic [5:0]        oct_sum;
    logic [3:0]        fold;
    logic              day_ok;
    cal_t              cal_next;

    assign quads     = elapsed[YEAR_BITS-1:2];
    assign quad_cent = centuries[Q100_W-1:2];

    // Year is a multiple of 100 when r mod 100 = 99, of 400 when r mod 400 = 399
    assign cent_mul = 7'({centuries, 6'b0}) + 7'({centuries, 5'b0}) + 7'({centuries, 2'b0});
    assign rem100   = elapsed[6:0] - cent_mul;
    assign quad_mul = 9'({quad_cent, 8'b0}) + 9'({quad_cent, 7'b0}) + 9'({quad_cent, 4'b0});
    assign rem400   = elapsed[8:0] - quad_mul;
    assign leap     = (elapsed[1:0] == 2'b11) && ((rem100 != 7'd99) || (rem400 == 9'd399));

    // Days before January 1 mod 7: 365 = 1 mod 7, so r + r/4 - r/100 + r/400
    assign day_sum = S_W'(elapsed) + S_W'(quads) + S_W'(quad_cent) - S_W'(centuries);
    assign sum_ext = EXT_W'(day_sum);

    // Octal digit sum, since 8 = 1 mod 7
    always_comb
    begin
        oct_sum = '0;
        for (int i = 0; i < ND; i++)
        begin
            oct_sum = oct_sum + 6'(sum_ext[3*i +: 3]);
        end
    end

    assign fold = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);

    // Day-of-month check and ordinal offset
    assign day_ok = (mday != '0) && (mday <= month_len(mon, leap));

    always_comb
    begin
        cal_next.ok   = date_ok && day_ok;
        cal_next.leap = leap;
        cal_next.jan1 = mod7_small(fold);
        cal_next.offs = days_before(mon, leap) + DOY_W'(mday) - DOY_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cal <= cal_next;
        end
    end

endmodule

[sv/dwwn_week.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwwn_week
// Last stage: weekday and Monday-start week number from the offset and the
// weekday of January 1; drives the result register.
// ----------------------------------------------------------------------------
module dwwn_week (
    input  logic                        clk,
    input  logic                        en,
    input  dwwn_pkg::cal_t              cal,
    output logic [dwwn_pkg::WD_W-1:0]   weekday,
    output logic [dwwn_pkg::WK_W-1:0]   week_number,
    output logic [dwwn_pkg::DOY_W-1:0]  day_of_year,
    output logic                        leap_year,
    output logic                        valid_res
);
    import dwwn_pkg::*;

    logic [DOY_W-1:0]  tot;
    logic [WK_P_W-1:0] prod;
    logic [WK_Q_W-1:0] weeks;
    logic [2:0]        rem;

    // tot / 7 by reciprocal; remainder low bits: tot - 7q = tot + q mod 8
    assign tot   = cal.offs + DOY_W'(cal.jan1);
    assign prod  = WK_P_W'(tot) * WK_P_W'(WK_DIV_M);
    assign weeks = prod[WK_DIV_K +: WK_Q_W];
    assign rem   = tot[2:0] + weeks[2:0];

    // Result register; a bad date gives all-zero fields
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cal.ok)
            begin
                weekday     <= rem + WD_W'(1);
                week_number <= WK_W'(weeks) + WK_W'(1);
                day_of_year <= cal.offs + DOY_W'(1);
                leap_year   <= cal.leap;
                valid_res   <= 1'b1;
            end
            else
            begin
                weekday     <= '0;
                week_number <= '0;
                day_of_year <= '0;
                leap_year   <= 1'b0;
                valid_res   <= 1'b0;
            end
        end
    end

endmodule

[sv/date_weekday_and_week_number.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_weekday_and_week_number
// Weekday, Monday-start week number, ordinal day and leap flag of a
// proleptic Gregorian date.
// ----------------------------------------------------------------------------
// Usage:
//   dates   : valid/ready channel carrying year, month and day.
//   results : valid/ready channel carrying weekday (1 = Monday), week_number
//             (week 1 holds January 1), day_of_year, leap_year and valid_res.
//             A year of zero, a bad month or a bad day gives valid_res = 0
//             with all other fields zero.
//   A date passes the input register, two arithmetic stages and the result
//   register in turn. Throughput: one date per cycle while the receiver
//   does not stall, set by the four-deep register pipeline; u_div and u_week
//   each hold a reciprocal multiply and u_cal holds the table lookups.
//   Reset clears the stage valid bits only; the pipeline is empty afterwards.
//   When the receiver stalls, the full stages hold and empty stages behind
//   them keep filling, so dates.ready drops only once all four stages hold a
//   transaction.
// ----------------------------------------------------------------------------
module date_weekday_and_week_number #(
    parameter int YEAR_BITS = dwwn_pkg::YEAR_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dwwn_in_if.sink   dates,
    dwwn_out_if.source results
);
    import dwwn_pkg::*;

    logic                 v0_reg, v1_reg, v2_reg, v3_reg;
    logic                 v0_next, v1_next, v2_next, v3_next;
    logic                 en0, en1, en2, en3;

    logic [YEAR_BITS-1:0] year_reg;
    logic [MONTH_W-1:0]   month_reg;
    logic [DAY_W-1:0]     day_reg;

    logic [YEAR_BITS-1:0] elapsed;
    logic [YEAR_BITS-7:0] centuries;
    logic [MONTH_W-1:0]   mon;
    logic [DAY_W-1:0]     mday;
    logic                 date_ok;
    cal_t                 cal;

    // Stage load enables: a stage loads when empty or when it drains
    assign en3 = !v3_reg || results.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;

    assign dates.ready   = en0;
    assign results.valid = v3_reg;

    always_comb
    begin
        v0_next = en0 ? dates.valid : v0_reg;
        v1_next = en1 ? v0_reg      : v1_reg;
        v2_next = en2 ? v1_reg      : v2_reg;
        v3_next = en3 ? v2_reg      : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            year_reg  <= dates.year;
            month_reg <= dates.month;
            day_reg   <= dates.day;
        end
    end

    dwwn_div #(
        .YEAR_BITS (YEAR_BITS)
    ) u_div (
        .clk       (clk),
        .en        (en1),
        .year      (year_reg),
        .month     (month_reg),
        .day       (day_reg),
        .elapsed   (elapsed),
        .centuries (centuries),
        .mon       (mon),
        .mday      (mday),
        .date_ok   (date_ok)
    );

    dwwn_cal #(
        .YEAR_BITS (YEAR_BITS)
    ) u_cal (
        .clk       (clk),
        .en        (en2),
        .elapsed   (elapsed),
        .centuries (centuries),
        .mon       (mon),
        .mday      (mday),
        .date_ok   (date_ok),
        .cal       (cal)
    );

    dwwn_week u_week (
        .clk         (clk),
        .en          (en3),
        .cal         (cal),
        .weekday     (results.weekday),
        .week_number (results.week_number),
        .day_of_year (results.day_of_year),
        .leap_year   (results.leap_year),
        .valid_res   (results.valid_res)
    );

endmodule

[sv/dwwn_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwwn_check
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dwwn_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [dwwn_pkg::WD_W-1:0]   weekday,
    input logic [dwwn_pkg::WK_W-1:0]   week_number,
    input logic [dwwn_pkg::DOY_W-1:0]  day_of_year,
    input logic                        leap_year,
    input logic                        valid_res
);
    import dwwn_pkg::*;

    int jan1_gap;

    // 7*(week-1) + weekday - day_of_year is the weekday index of January 1
    assign jan1_gap = 7 * (int'(week_number) - 1) + int'(weekday) - int'(day_of_year);

    // No result in the cycle after reset was seen low
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weekday) && $stable(week_number)
            && $stable(day_of_year) && $stable(leap_year) && $stable(valid_res))
        else $error("stalled result changed");

    // Bad date reports all zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> weekday == '0 && week_number == '0
            && day_of_year == '0 && !leap_year)
        else $error("bad date with nonzero fields");

    // Week number and weekday agree with the ordinal day
    a_week_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> jan1_gap >= 0 && jan1_gap <= 6 && weekday != '0)
        else $error("week number inconsistent with weekday and ordinal day");

    // Day 366 only in a leap year
    a_doy_leap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res && day_of_year == 9'd366 |-> leap_year)
        else $error("day 366 in a common year");

endmodule

bind date_weekday_and_week_number dwwn_check u_dwwn_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .weekday     (results.weekday),
    .week_number (results.week_number),
    .day_of_year (results.day_of_year),
    .leap_year   (results.leap_year),
    .valid_res   (results.valid_res)
);

[tb/tb_date_weekday_and_week_number.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_date_weekday_and_week_number
// Self-checking regression for the Gregorian weekday and week number block.
// Dates go in on the valid/ready input channel. Each accepted transaction is
// run through a local calendar computation. Each result transaction is
// compared field by field with the oldest pending prediction. Directed calendar
// corners and rejected dates come first. Random dates follow, mostly
// well-formed with some malformed ones, under four handshake pressure phases.
// ----------------------------------------------------------------------------
module tb_date_weekday_and_week_number;
    import dwwn_pkg::*;

    localparam int YB          = YEAR_BITS_DEF;
    localparam int IDLE_LIMIT  = 2000;   // cycles without any transaction
    localparam int RANDOM_ITEMS = 356;   // per handshake phase

    // Expected result of one date
    typedef struct packed {
        logic [WD_W-1:0]  weekday;
        logic [WK_W-1:0]  week_number;
        logic [DOY_W-1:0] day_of_year;
        logic             leap_year;
        logic             valid_res;
    } day_info_t;

    logic clk;
    logic rst_n;

    dwwn_in_if #(.YEAR_BITS(YB)) dates_if ();
    dwwn_out_if                  results_if ();

    date_weekday_and_week_number #(
        .YEAR_BITS (YB)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .dates   (dates_if),
        .results (results_if)
    );

    day_info_t pending_results[$];
    int        idle_pct;
    int        stall_pct;
    int        mismatches;
    int        good_dates;
    int        rejected_dates;
    int        top_week;
    int        quiet_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Days in a month; 0 for a month number outside the year
    function automatic int days_in_month(input int m, input bit leap);
        int lengths [12];
        lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12)
        begin
            return 0;
        end
        return lengths[m-1] + ((m == 2 && leap) ? 1 : 0);
    endfunction

    function automatic bit is_leap(input int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    // Calendar computation of one date
    function automatic day_info_t calendar_of_date(input logic [YB-1:0] y_in,
                                                   input logic [MONTH_W-1:0] m_in,
                                                   input logic [DAY_W-1:0] d_in);
        day_info_t info;
        int        y;
        int        m;
        int        d;
        bit        leap;
        int        ordinal;
        int        elapsed;
        int        rem;
        int        jan1;
        info    = '0;
        y       = int'(y_in);
        m       = int'(m_in);
        d       = int'(d_in);
        if (y == 0 || m < 1 || m > 12)
        begin
            return info;
        end
        leap = is_leap(y);
        if (d < 1 || d > days_in_month(m, leap))
        begin
            return info;
        end
        // zero-based ordinal day
        ordinal = d - 1;
        for (int k = 1; k < m; k++)
        begin
            ordinal += days_in_month(k, leap);
        end
        // days from 0001-01-01 to January 1 of this year, in whole cycles
        rem     = y - 1;
        elapsed = (rem / 400) * 146097;
        rem     = rem % 400;
        elapsed += (rem / 100) * 36524;
        rem     = rem % 100;
        elapsed += (rem / 4) * 1461;
        elapsed += (rem % 4) * 365;
        jan1    = (elapsed + 1) % 7;
        if (jan1 == 0)
        begin
            jan1 = 7;
        end
        info.weekday     = WD_W'(((jan1 - 1 + ordinal) % 7) + 1);
        info.week_number = WK_W'((ordinal + jan1 - 1) / 7 + 1);
        info.day_of_year = DOY_W'(ordinal + 1);
        info.leap_year   = leap;
        info.valid_res   = 1'b1;
        return info;
    endfunction

    // Result checking and prediction on accepted transactions
    always @(posedge clk)
    begin
        day_info_t got;
        day_info_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            got.weekday     = results_if.weekday;
            got.week_number = results_if.week_number;
            got.day_of_year = results_if.day_of_year;
            got.leap_year   = results_if.leap_year;
            got.valid_res   = results_if.valid_res;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: unexpected result transaction wd=%0d wk=%0d doy=%0d leap=%0b ok=%0b",
                             got.weekday, got.week_number, got.day_of_year,
                             got.leap_year, got.valid_res);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.weekday !== want.weekday || got.week_number !== want.week_number ||
                    got.day_of_year !== want.day_of_year ||
                    got.leap_year !== want.leap_year || got.valid_res !== want.valid_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: at %0t expected wd=%0d wk=%0d doy=%0d leap=%0b ok=%0b",
                                 $realtime, want.weekday, want.week_number,
                                 want.day_of_year, want.leap_year, want.valid_res);
                        $display("       actual   wd=%0d wk=%0d doy=%0d leap=%0b ok=%0b",
                                 got.weekday, got.week_number, got.day_of_year,
                                 got.leap_year, got.valid_res);
                    end
                end
                if (want.valid_res)
                begin
                    good_dates++;
                    if (int'(want.week_number) > top_week)
                    begin
                        top_week = int'(want.week_number);
                    end
                end
                else
                begin
                    rejected_dates++;
                end
            end
        end
        if (rst_n && dates_if.valid && dates_if.ready)
        begin
            pending_results.push_back(calendar_of_date(dates_if.year, dates_if.month,
                                                       dates_if.day));
        end
    end

    // Watchdog: no transaction on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (dates_if.valid && dates_if.ready) ||
            (results_if.valid && results_if.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles, %0d results pending",
                         IDLE_LIMIT, pending_results.size());
                $display("date_weekday_and_week_number regression: fail");
                $finish;
            end
        end
    end

    // Receiver back-pressure
    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            results_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Send one date; returns after the edge that accepts it
    task automatic push_date(input logic [YB-1:0] y, input logic [MONTH_W-1:0] m,
                             input logic [DAY_W-1:0] d);
        while ($urandom_range(99) < idle_pct)
        begin
            dates_if.valid <= 1'b0;
            dates_if.year  <= YB'($urandom);
            dates_if.month <= MONTH_W'($urandom);
            dates_if.day   <= DAY_W'($urandom);
            @(posedge clk);
        end
        dates_if.valid <= 1'b1;
        dates_if.year  <= y;
        dates_if.month <= m;
        dates_if.day   <= d;
        @(posedge clk);
        while (dates_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
    endtask

    // Valid calendar corners: epoch, leap rules, year end, widest week count
    task automatic test_calendar_corners();
        idle_pct  = 0;
        stall_pct = 0;
        push_date(YB'(1), 4'd1, 5'd1);
        push_date(YB'(1), 4'd12, 5'd31);
        push_date(YB'(2000), 4'd2, 5'd29);
        push_date(YB'(1900), 4'd2, 5'd28);
        push_date(YB'(1900), 4'd3, 5'd1);
        push_date(YB'(2024), 4'd2, 5'd29);
        push_date(YB'(2012), 4'd12, 5'd31);
        push_date(YB'(2000), 4'd12, 5'd31);
        push_date(YB'(2023), 4'd12, 5'd31);
        push_date(YB'(400), 4'd1, 5'd1);
        push_date(YB'(401), 4'd1, 5'd1);
        push_date({YB{1'b1}}, 4'd12, 5'd31);
        push_date({YB{1'b1}}, 4'd1, 5'd1);
    endtask

    // Rejected dates: year zero, month out of range, day zero or past month end
    task automatic test_rejected_dates();
        idle_pct  = 0;
        stall_pct = 0;
        push_date(YB'(0), 4'd1, 5'd1);
        push_date(YB'(0), 4'd15, 5'd31);
        push_date(YB'(2021), 4'd0, 5'd10);
        push_date(YB'(2021), 4'd13, 5'd10);
        push_date(YB'(2021), 4'd15, 5'd31);
        push_date(YB'(2021), 4'd5, 5'd0);
        push_date(YB'(2021), 4'd4, 5'd31);
        push_date(YB'(1900), 4'd2, 5'd29);
        push_date(YB'(2023), 4'd2, 5'd29);
        push_date(YB'(2024), 4'd2, 5'd30);
        push_date({YB{1'b1}}, 4'd15, 5'd31);
    endtask

    // Random dates, mostly well-formed, under one handshake pressure setting
    task automatic test_random_dates(input int idle_setting, input int stall_setting,
                                     input int count);
        logic [YB-1:0]      y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
        int                 len;
        idle_pct  = idle_setting;
        stall_pct = stall_setting;
        for (int n = 0; n < count; n++)
        begin
            // year mix: full range, around century boundaries, years up to 3000
            case ($urandom_range(3))
                0:       y = YB'($urandom_range((1 << YB) - 1, 1));
                1:       y = YB'($urandom_range(163, 1) * 100 + $urandom_range(2) - 1);
                2:       y = YB'($urandom_range(3000, 1));
                default: y = YB'($urandom);
            endcase
            if (y == 0)
            begin
                y = YB'(1);
            end
            m   = MONTH_W'($urandom_range(12, 1));
            len = days_in_month(int'(m), is_leap(int'(y)));
            d   = ($urandom_range(5) == 0) ? DAY_W'(len) : DAY_W'($urandom_range(len, 1));
            // a quarter of the dates are broken or pure noise
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(4))
                    0:       y = '0;
                    1:       m = ($urandom_range(1) == 0) ? 4'd0 : MONTH_W'($urandom_range(15, 13));
                    2:       d = '0;
                    3:       d = DAY_W'(len + 1);
                    default:
                    begin
                        y = YB'($urandom);
                        m = MONTH_W'($urandom);
                        d = DAY_W'($urandom);
                    end
                endcase
            end
            push_date(y, m, d);
        end
    endtask

    // Sequence of tests
    initial
    begin
        mismatches     = 0;
        good_dates     = 0;
        rejected_dates = 0;
        top_week       = 0;
        quiet_cycles   = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        rst_n          = 1'b0;
        dates_if.valid = 1'b0;
        dates_if.year  = '0;
        dates_if.month = '0;
        dates_if.day   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_calendar_corners();
        test_rejected_dates();
        test_random_dates(0, 0, RANDOM_ITEMS);
        test_random_dates(49, 0, RANDOM_ITEMS);
        test_random_dates(0, 49, RANDOM_ITEMS);
        test_random_dates(15, 15, RANDOM_ITEMS);
        dates_if.valid <= 1'b0;

        // drain, then allow for the pipeline depth
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("ERROR: %0d results never arrived", pending_results.size());
        end

        $display("Checked %0d dates: %0d valid, %0d rejected, %0d mismatches",
                 good_dates + rejected_dates, good_dates, rejected_dates, mismatches);
        $display("Handshake phases: free flow, sender gaps, receiver stalls, both; top week %0d",
                 top_week);
        if (mismatches == 0)
        begin
            $display("date_weekday_and_week_number regression: pass");
        end
        else
        begin
            $display("date_weekday_and_week_number regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
sv/dwwn_pkg.sv
sv/dwwn_if.sv
sv/dwwn_div.sv
sv/dwwn_cal.sv
sv/dwwn_week.sv
sv/date_weekday_and_week_number.sv
sv/dwwn_check.sv
tb/tb_date_weekday_and_week_number.sv
